// ===== src/pls_pkg.sv =====
`default_nettype none

package pls_pkg;

  localparam int unsigned REQ_W       = 3;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 5;

  localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_TAIL = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_POS  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_HEAD = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DEL_TAIL = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DEL_POS  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_DISPLAY  = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  localparam logic [1:0] KIND_SINGLE  = 2'd0;
  localparam logic [1:0] KIND_INSERT  = 2'd1;
  localparam logic [1:0] KIND_DELETE  = 2'd2;
  localparam logic [1:0] KIND_DISPLAY = 2'd3;

  typedef struct packed {
    logic load;
    logic decode;
    logic up_step;
    logic dn_step;
    logic place;
    logic count_dec;
    logic emit_single;
    logic disp_emit;
  } pls_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       ins_more;
    logic       del_more;
    logic       copy_busy;
    logic       out_free;
    logic       disp_last;
  } pls_sts_t;

endpackage

`default_nettype wire

// ===== src/pls_if.sv =====
`default_nettype none

interface pls_req_if import pls_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, output req_type, output value, output position, input ready);
  modport sink   (input valid, input req_type, input value, input position, output ready);
endinterface

interface pls_rsp_if import pls_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] element;
  logic                      element_valid;
  logic [COUNT_OUT_W-1:0]    entry_count;
  logic                      last;

  modport source (output valid, output status, output element, output element_valid,
                  output entry_count, output last, input ready);
  modport sink   (input valid, input status, input element, input element_valid,
                  input entry_count, input last, output ready);
endinterface

`default_nettype wire

// ===== src/pls_ram.sv =====
`default_nettype none

module pls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/pls_ctrl.sv =====
`default_nettype none

module pls_ctrl import pls_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire pls_sts_t sts,
  output pls_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DECODE    = 3'd1;
  localparam logic [2:0] S_INS_SHIFT = 3'd2;
  localparam logic [2:0] S_INS_PLACE = 3'd3;
  localparam logic [2:0] S_DEL_SHIFT = 3'd4;
  localparam logic [2:0] S_DEL_DRAIN = 3'd5;
  localparam logic [2:0] S_EMIT      = 3'd6;
  localparam logic [2:0] S_DISP      = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        unique case (sts.kind)
          KIND_INSERT:  state_next = S_INS_SHIFT;
          KIND_DELETE:  state_next = S_DEL_SHIFT;
          KIND_DISPLAY: state_next = S_DISP;
          KIND_SINGLE:  state_next = S_EMIT;
        endcase
      end
      S_INS_SHIFT: begin
        if (sts.ins_more) begin
          cmd.up_step = 1'b1;
        end else begin
          state_next = S_INS_PLACE;
        end
      end
      S_INS_PLACE: begin
        if (!sts.copy_busy) begin
          cmd.place  = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_DEL_SHIFT: begin
        if (sts.del_more) begin
          cmd.dn_step = 1'b1;
        end else begin
          state_next = S_DEL_DRAIN;
        end
      end
      S_DEL_DRAIN: begin
        if (!sts.copy_busy) begin
          cmd.count_dec = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_DISP: begin
        if (sts.out_free) begin
          cmd.disp_emit = 1'b1;
          if (sts.disp_last) begin
            state_next = S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/pls_datapath.sv =====
`default_nettype none

module pls_datapath import pls_pkg::*; #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire pls_cmd_t                  cmd,
  output pls_sts_t                       sts,
  input  wire logic [REQ_W-1:0]          req_type,
  input  wire logic signed [VALUE_W-1:0] value,
  input  wire logic [POS_W-1:0]          position,
  input  wire logic                      rsp_ready,
  output logic                           rsp_valid,
  output logic [STATUS_W-1:0]            rsp_status,
  output logic signed [VALUE_W-1:0]      rsp_element,
  output logic                           rsp_element_valid,
  output logic [COUNT_OUT_W-1:0]         rsp_entry_count,
  output logic                           rsp_last
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [REQ_W-1:0]      req_type_q;
  logic [VALUE_W-1:0]    value_q;
  logic [POS_W-1:0]      pos_q;
  logic [CW-1:0]         count;
  logic [AW-1:0]         idx_q;
  logic [AW-1:0]         ptr;
  logic [STATUS_W-1:0]   status_q;
  logic                  copy_q;
  logic [AW-1:0]         copy_addr_q;

  logic [1:0]            dec_kind;
  logic [STATUS_W-1:0]   dec_status;
  logic [AW-1:0]         dec_idx;

  logic [CMPW-1:0]       pos_x;
  logic [CMPW-1:0]       cnt_x;
  logic [CMPW-1:0]       pos_m1;
  logic [CW-1:0]         cnt_m1;
  logic [CW-1:0]         ptr_p1;
  logic                  full;
  logic                  empty;
  logic                  pos_ok_ins;
  logic                  pos_ok_del;
  logic                  disp_last;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic [DATA_WIDTH+VALUE_W-1:0]  value_ext;
  logic [DATA_WIDTH+VALUE_W-1:0]  rdata_ext;
  logic [CW+COUNT_OUT_W-1:0]      count_ext;

  assign pos_x      = CMPW'(pos_q);
  assign cnt_x      = CMPW'(count);
  assign pos_m1     = pos_x - CMPW'(1);
  assign cnt_m1     = count - CW'(1);
  assign ptr_p1     = CW'(ptr) + CW'(1);
  assign full       = (count == CW'(CAPACITY));
  assign empty      = (count == '0);
  assign pos_ok_ins = (pos_x != '0) && (pos_x <= cnt_x + CMPW'(1));
  assign pos_ok_del = (pos_x != '0) && (pos_x <= cnt_x);
  assign disp_last  = (ptr_p1 == count);

  assign value_ext = {{DATA_WIDTH{1'b0}}, value_q};
  assign rdata_ext = {{VALUE_W{1'b0}}, ram_rdata};
  assign count_ext = {{COUNT_OUT_W{1'b0}}, count};

  always_comb begin
    dec_kind   = KIND_SINGLE;
    dec_status = ST_OK;
    dec_idx    = '0;
    unique case (req_type_q)
      REQ_INS_HEAD: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_kind = KIND_INSERT;
        end
      end
      REQ_INS_TAIL: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_kind = KIND_INSERT;
          dec_idx  = AW'(count);
        end
      end
      REQ_INS_POS: begin
        if (!pos_ok_ins) begin
          dec_status = ST_BADPOS;
        end else if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_kind = KIND_INSERT;
          dec_idx  = pos_m1[AW-1:0];
        end
      end
      REQ_DEL_HEAD: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_kind = KIND_DELETE;
        end
      end
      REQ_DEL_TAIL: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_kind = KIND_DELETE;
          dec_idx  = AW'(cnt_m1);
        end
      end
      REQ_DEL_POS: begin
        if (!pos_ok_del) begin
          dec_status = ST_BADPOS;
        end else begin
          dec_kind = KIND_DELETE;
          dec_idx  = pos_m1[AW-1:0];
        end
      end
      REQ_DISPLAY: begin
        if (!empty) begin
          dec_kind = KIND_DISPLAY;
        end
      end
      default: begin
        dec_status = ST_BADPOS;
      end
    endcase
  end

  always_comb begin
    sts.kind      = dec_kind;
    sts.ins_more  = (ptr > idx_q);
    sts.del_more  = (ptr_p1 < count);
    sts.copy_busy = copy_q;
    sts.out_free  = !rsp_valid || rsp_ready;
    sts.disp_last = disp_last;
  end

  // pending shift copy takes the write port first
  assign ram_we    = copy_q || cmd.place;
  assign ram_waddr = copy_q ? copy_addr_q : idx_q;
  assign ram_wdata = copy_q ? ram_rdata : value_ext[DATA_WIDTH-1:0];
  assign ram_re    = cmd.decode || cmd.up_step || cmd.dn_step ||
                     (cmd.disp_emit && !disp_last);

  always_comb begin
    priority if (cmd.up_step) begin
      ram_raddr = ptr - AW'(1);
    end else if (cmd.dn_step || cmd.disp_emit) begin
      ram_raddr = ptr + AW'(1);
    end else begin
      ram_raddr = '0;
    end
  end

  pls_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      copy_q    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      copy_q <= cmd.up_step || cmd.dn_step;
      if (cmd.place) begin
        count <= count + CW'(1);
      end else if (cmd.count_dec) begin
        count <= cnt_m1;
      end
      if (cmd.emit_single || cmd.disp_emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_q <= req_type;
      value_q    <= value;
      pos_q      <= position;
    end
    if (cmd.decode) begin
      status_q <= dec_status;
      idx_q    <= dec_idx;
      priority if (dec_kind == KIND_INSERT) begin
        ptr <= AW'(count);
      end else if (dec_kind == KIND_DELETE) begin
        ptr <= dec_idx;
      end else begin
        ptr <= '0;
      end
    end
    if (cmd.up_step) begin
      ptr         <= ptr - AW'(1);
      copy_addr_q <= ptr;
    end
    if (cmd.dn_step) begin
      ptr         <= ptr + AW'(1);
      copy_addr_q <= ptr;
    end
    if (cmd.disp_emit) begin
      ptr <= ptr + AW'(1);
    end
    if (cmd.emit_single) begin
      rsp_status        <= status_q;
      rsp_element       <= '0;
      rsp_element_valid <= 1'b0;
      rsp_entry_count   <= count_ext[COUNT_OUT_W-1:0];
      rsp_last          <= 1'b1;
    end
    if (cmd.disp_emit) begin
      rsp_status        <= ST_OK;
      rsp_element       <= rdata_ext[VALUE_W-1:0];
      rsp_element_valid <= 1'b1;
      rsp_entry_count   <= count_ext[COUNT_OUT_W-1:0];
      rsp_last          <= disp_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_place_no_copy: assert property (@(posedge clk) disable iff (rst)
    cmd.place |-> !copy_q)
    else $error("value write collides with shift copy");

  a_place_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.place |-> !full)
    else $error("insert into full store");

  a_disp_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.disp_emit |-> (CW'(ptr) < count))
    else $error("display reads beyond stored entries");

endmodule

`default_nettype wire

// ===== src/positional_list_store.sv =====
`default_nettype none

// channel  dir  handshake      payload
// req      in   valid/ready    req_type, value, position
// rsp      out  valid/ready    status, element, element_valid, entry_count, last
//
// An item is taken only while the controller is idle; the result register lets
// the next item in while the previous result still waits.
// Insert: decode, shift loop, place, emit. Delete: decode, shift loop, drain, emit.
// Others: decode, emit. Display: decode, then one entry a cycle unless rsp stalls.
// The next item can be taken in the cycle after the final result is loaded.
// The shift loop copies one entry a cycle through the store's single write port.
// Reset clears the count and the control state; stored entries are not cleared.
// Back-pressure on rsp holds the controller in its emit or display state.

module positional_list_store import pls_pkg::*; #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pls_req_if.sink    req,
  pls_rsp_if.source  rsp
);

  pls_cmd_t cmd;
  pls_sts_t sts;

  pls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pls_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .req_type          (req.req_type),
    .value             (req.value),
    .position          (req.position),
    .rsp_ready         (rsp.ready),
    .rsp_valid         (rsp.valid),
    .rsp_status        (rsp.status),
    .rsp_element       (rsp.element),
    .rsp_element_valid (rsp.element_valid),
    .rsp_entry_count   (rsp.entry_count),
    .rsp_last          (rsp.last)
  );

endmodule

`default_nettype wire

// ===== tb/positional_list_store_tb.sv =====
`timescale 1ns / 1ps

module positional_list_store_tb import pls_pkg::*; ();

  localparam int CAP          = 16;
  localparam int LIMIT        = 250000;
  localparam int STALL_LEN    = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 146;
  localparam int SEG_ITEMS    = 24;

  localparam logic [REQ_W-1:0]   REQ_UNUSED = 3'd7;
  localparam logic [VALUE_W-1:0] VAL_MAX    = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VAL_MIN    = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VAL_NEG1   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } req_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] element;
    logic                      element_valid;
    logic [COUNT_OUT_W-1:0]    entry_count;
    logic                      last;
  } rsp_item_t;

  typedef rsp_item_t rsp_q_t[$];

  typedef struct {
    req_item_t              item;
    bit                     typed;
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] count;
  } dir_row_t;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_ANY} mix_t;

  logic clk;
  logic rst;

  pls_req_if req_ch ();
  pls_rsp_if rsp_ch ();

  positional_list_store #(.CAPACITY(CAP), .DATA_WIDTH(VALUE_W)) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  logic signed [VALUE_W-1:0] list_model[$];
  rsp_item_t                 pending[$];
  dir_row_t                  directed_tbl[$];
  rsp_item_t                 seen_rsp;
  rsp_item_t                 want_rsp;

  int errors       = 0;
  int cycles       = 0;
  int send_gap_pct = 8;
  int recv_gap_pct = 60;
  int stall_asks   = 0;
  int stall_done   = 0;
  int stall_left   = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic rsp_item_t make_rsp(input logic [STATUS_W-1:0] st,
                                         input logic signed [VALUE_W-1:0] el,
                                         input logic ev, input int cnt, input logic lst);
    rsp_item_t r;
    r.status        = st;
    r.element       = el;
    r.element_valid = ev;
    r.entry_count   = COUNT_OUT_W'(cnt);
    r.last          = lst;
    return r;
  endfunction

  function automatic logic [STATUS_W-1:0] place_entry(input int idx,
                                                      input logic signed [VALUE_W-1:0] v);
    if (list_model.size() >= CAP) return ST_FULL;
    list_model.insert(idx, v);
    return ST_OK;
  endfunction

  function automatic void forecast(input req_item_t it, output rsp_q_t res);
    logic [STATUS_W-1:0] st;
    int n;
    int pos;
    st  = ST_OK;
    n   = list_model.size();
    pos = int'(it.position);
    res = {};
    case (it.req_type)
      REQ_INS_HEAD: st = place_entry(0, it.value);
      REQ_INS_TAIL: st = place_entry(n, it.value);
      REQ_INS_POS: begin
        if (pos < 1 || pos > n + 1) st = ST_BADPOS;
        else st = place_entry(pos - 1, it.value);
      end
      REQ_DEL_HEAD: begin
        if (n == 0) st = ST_EMPTY;
        else list_model.delete(0);
      end
      REQ_DEL_TAIL: begin
        if (n == 0) st = ST_EMPTY;
        else list_model.delete(n - 1);
      end
      REQ_DEL_POS: begin
        if (pos < 1 || pos > n) st = ST_BADPOS;
        else list_model.delete(pos - 1);
      end
      REQ_DISPLAY: st = ST_OK;
      default: st = ST_BADPOS;
    endcase
    if (it.req_type == REQ_DISPLAY && n != 0) begin
      for (int i = 0; i < n; i++)
        res.push_back(make_rsp(ST_OK, list_model[i], 1'b1, n, i == n - 1));
    end else begin
      res.push_back(make_rsp(st, '0, 1'b0, list_model.size(), 1'b1));
    end
  endfunction

  function automatic req_item_t random_req(input mix_t mix);
    req_item_t it;
    int w[8];
    int r;
    int acc;
    int hi;
    it  = '0;
    acc = 0;
    case (mix)
      MIX_GROW:   w = '{27, 27, 26, 3, 3, 4, 8, 2};
      MIX_SHRINK: w = '{5, 5, 6, 22, 22, 28, 9, 3};
      default:    w = '{13, 13, 13, 13, 13, 13, 13, 9};
    endcase
    r = $urandom_range(0, 99);
    for (int t = 0; t < 8; t++) begin
      acc += w[t];
      if (r < acc) begin
        it.req_type = REQ_W'(t);
        break;
      end
    end
    hi = (it.req_type == REQ_INS_POS) ? list_model.size() + 1 : list_model.size();
    if ($urandom_range(0, 9) < 8 && hi >= 1) it.position = POS_W'($urandom_range(1, hi));
    else it.position = POS_W'($urandom_range(0, 17));
    case ($urandom_range(0, 15))
      0:       it.value = VAL_MAX;
      1:       it.value = VAL_MIN;
      2:       it.value = '0;
      3:       it.value = VAL_NEG1;
      default: it.value = $urandom;
    endcase
    return it;
  endfunction

  function automatic dir_row_t row(input logic [REQ_W-1:0] rt, input logic [VALUE_W-1:0] v,
                                   input int pos, input bit typed,
                                   input logic [STATUS_W-1:0] st, input int cnt);
    dir_row_t d;
    d.item.req_type = rt;
    d.item.value    = v;
    d.item.position = POS_W'(pos);
    d.typed         = typed;
    d.status        = st;
    d.count         = COUNT_OUT_W'(cnt);
    return d;
  endfunction

  function automatic string fmt_rsp(input rsp_item_t r);
    return $sformatf("st=%0d el=%h ev=%0b cnt=%0d last=%0b",
                     r.status, r.element, r.element_valid, r.entry_count, r.last);
  endfunction

  task automatic send_req(input req_item_t it, input bit typed, input rsp_item_t typed_rsp);
    rsp_q_t res;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= it.req_type;
    req_ch.value    <= it.value;
    req_ch.position <= it.position;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    forecast(it, res);
    if (typed) res = {typed_rsp};
    foreach (res[i]) pending.push_back(res[i]);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  // hold ready low for a long stretch when asked
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (stall_done != stall_asks) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= STALL_LEN;
      stall_done   <= stall_done + 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      seen_rsp.status        = rsp_ch.status;
      seen_rsp.element       = rsp_ch.element;
      seen_rsp.element_valid = rsp_ch.element_valid;
      seen_rsp.entry_count   = rsp_ch.entry_count;
      seen_rsp.last          = rsp_ch.last;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result with nothing pending: %s", $time, fmt_rsp(seen_rsp));
      end else begin
        want_rsp = pending.pop_front();
        if (seen_rsp.status !== want_rsp.status || seen_rsp.element !== want_rsp.element ||
            seen_rsp.element_valid !== want_rsp.element_valid ||
            seen_rsp.entry_count !== want_rsp.entry_count || seen_rsp.last !== want_rsp.last) begin
          errors++;
          if (errors <= 10)
            $display("%0t: mismatch: got %s expected %s", $time, fmt_rsp(seen_rsp),
                     fmt_rsp(want_rsp));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("positional_list_store_tb: errors");
      $finish;
    end
  end

  initial begin
    mix_t mix;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_INS_HEAD;
    req_ch.value    = '0;
    req_ch.position = '0;
    mix             = MIX_GROW;

    directed_tbl.push_back(row(REQ_DISPLAY,  '0,           0, 1, ST_OK,     0));
    directed_tbl.push_back(row(REQ_DEL_HEAD, '0,           0, 1, ST_EMPTY,  0));
    directed_tbl.push_back(row(REQ_DEL_TAIL, '0,           0, 1, ST_EMPTY,  0));
    directed_tbl.push_back(row(REQ_DEL_POS,  '0,           1, 1, ST_BADPOS, 0));
    directed_tbl.push_back(row(REQ_INS_POS,  32'd5,        0, 1, ST_BADPOS, 0));
    directed_tbl.push_back(row(REQ_INS_POS,  32'd5,        2, 1, ST_BADPOS, 0));
    directed_tbl.push_back(row(REQ_UNUSED,   VAL_NEG1,    17, 1, ST_BADPOS, 0));
    directed_tbl.push_back(row(REQ_INS_HEAD, VAL_MAX,      0, 1, ST_OK,     1));
    directed_tbl.push_back(row(REQ_INS_TAIL, VAL_MIN,      0, 1, ST_OK,     2));
    directed_tbl.push_back(row(REQ_INS_POS,  VAL_NEG1,     2, 1, ST_OK,     3));
    directed_tbl.push_back(row(REQ_INS_POS,  '0,           4, 1, ST_OK,     4));
    directed_tbl.push_back(row(REQ_DISPLAY,  '0,           0, 0, ST_OK,     0));
    directed_tbl.push_back(row(REQ_DEL_POS,  '0,           0, 1, ST_BADPOS, 4));
    directed_tbl.push_back(row(REQ_DEL_POS,  '0,           5, 1, ST_BADPOS, 4));
    directed_tbl.push_back(row(REQ_DEL_POS,  '0,          17, 1, ST_BADPOS, 4));
    directed_tbl.push_back(row(REQ_INS_POS,  32'd7,       17, 1, ST_BADPOS, 4));
    directed_tbl.push_back(row(REQ_DEL_POS,  '0,           2, 1, ST_OK,     3));
    directed_tbl.push_back(row(REQ_DISPLAY,  '0,           0, 0, ST_OK,     0));
    directed_tbl.push_back(row(REQ_DEL_HEAD, '0,           0, 1, ST_OK,     2));
    directed_tbl.push_back(row(REQ_DEL_TAIL, '0,           0, 1, ST_OK,     1));
    directed_tbl.push_back(row(REQ_DISPLAY,  '0,           0, 0, ST_OK,     0));
    directed_tbl.push_back(row(REQ_INS_TAIL, 32'h5A5A_A5A5, 16, 1, ST_OK,   2));
    directed_tbl.push_back(row(REQ_DISPLAY,  '0,           0, 0, ST_OK,     0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_tbl[i])
      send_req(directed_tbl[i].item, directed_tbl[i].typed,
               make_rsp(directed_tbl[i].status, '0, 1'b0, directed_tbl[i].count, 1'b1));

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_gap_pct = 8;
          recv_gap_pct = 60;
        end
        1: begin
          send_gap_pct = 60;
          recv_gap_pct = 8;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % SEG_ITEMS == 0) mix = mix_t'((k / SEG_ITEMS + ph) % 3);
        if (k == 60 && ph != 1) stall_asks++;
        send_req(random_req(mix), 1'b0, '0);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("positional_list_store_tb: clean");
    end else begin
      $display("positional_list_store_tb: errors");
    end
    $finish;
  end

endmodule
